>>> hdl/bpdc_pkg.sv
// Package for the button packet drive controller: widths, character codes, register indices, reset values and types.
package bpdc_pkg;

    localparam int unsigned STEP_W  = 4;
    localparam int unsigned TICKS_W = 16;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned SPEED_W = 5;
    localparam int unsigned BYTE_W  = 8;

    localparam logic [BYTE_W-1:0] CH_START  = 8'h21;
    localparam logic [BYTE_W-1:0] CH_BUTTON = 8'h42;
    localparam logic [BYTE_W-1:0] CH_BRAKE  = 8'h33;
    localparam logic [BYTE_W-1:0] CH_UP     = 8'h35;
    localparam logic [BYTE_W-1:0] CH_DOWN   = 8'h36;
    localparam logic [BYTE_W-1:0] CH_LEFT   = 8'h37;
    localparam logic [BYTE_W-1:0] CH_RIGHT  = 8'h38;
    localparam logic [BYTE_W-1:0] CH_PRESS  = 8'h31;

    localparam logic [STEP_W-1:0] LIMIT_CAP = 4'd10;

    localparam logic [IDX_W-1:0] CFG_BRAKE_STEP    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SPEED_STEP    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MAX_MAGNITUDE = 2'd2;
    localparam logic [IDX_W-1:0] CFG_TURN_TICKS    = 2'd3;

    localparam logic [STEP_W-1:0]  RST_BRAKE_STEP    = 4'd1;
    localparam logic [STEP_W-1:0]  RST_SPEED_STEP    = 4'd1;
    localparam logic [STEP_W-1:0]  RST_MAX_MAGNITUDE = 4'd10;
    localparam logic [TICKS_W-1:0] RST_TURN_TICKS    = 16'd2000;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [2:0] {
        PH_WAIT_START  = 3'd0,
        PH_WAIT_BUTTON = 3'd1,
        PH_GET_CODE    = 3'd2,
        PH_GET_PRESS   = 3'd3,
        PH_GET_CHECK   = 3'd4
    } t_phase;

    typedef logic signed [SPEED_W-1:0] t_speed;

endpackage

>>> hdl/bpdc_in_if.sv
// Input channel carrying one received byte or one millisecond tick per word.
interface bpdc_in_if;
    import bpdc_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

>>> hdl/bpdc_out_if.sv
// Output channel carrying the drive and status word produced for each input word.
interface bpdc_out_if;
    import bpdc_pkg::*;

    logic         valid;
    logic         ready;
    logic signed [SPEED_W-1:0] right_drive;
    logic signed [SPEED_W-1:0] left_drive;
    logic         reverse_gear;
    logic         turning;
    logic         packet_accepted;

    modport source (output valid, output right_drive, output left_drive, output reverse_gear,
                    output turning, output packet_accepted, input ready);
    modport sink   (input valid, input right_drive, input left_drive, input reverse_gear,
                    input turning, input packet_accepted, output ready);
endinterface

>>> hdl/button_packet_drive_controller_unit.sv
// Top level of the button packet drive controller: packet parser, speed logic and turn timer.
//
//  Channel  Direction  Handshake      Contents
//  i_in     in         valid/ready    command, rx_byte
//  o_out    out        valid/ready    right_drive, left_drive, reverse_gear, turning,
//                                     packet_accepted
//  i_cfg_*  in         write enable   register index and data
//
// Each word is taken into an input register and its result is formed in an output
// register, so one word is accepted every cycle while the output is not stalled. The
// output register decides the rate: a word waits in the input register while the
// output is stalled. Reset is synchronous and clears the control state and restores
// the register defaults.
module button_packet_drive_controller_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bpdc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [bpdc_pkg::CFG_W-1:0]   i_cfg_data,
    bpdc_in_if.sink                      i_in,
    bpdc_out_if.source                   o_out
);
    import bpdc_pkg::*;

    logic [STEP_W-1:0]  r_brake_step;
    logic [STEP_W-1:0]  r_speed_step;
    logic [STEP_W-1:0]  r_max_magnitude;
    logic [TICKS_W-1:0] r_turn_ticks;

    logic              r_in_valid;
    logic              r_in_command;
    logic [BYTE_W-1:0] r_in_byte;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_button, n_button;
    logic [BYTE_W-1:0] r_press, n_press;
    t_speed            r_right, n_right;
    t_speed            r_left, n_left;
    logic              r_reverse, n_reverse;
    logic              r_turn, n_turn;
    logic              r_turn_right, n_turn_right;
    logic [TICKS_W-1:0] r_remaining, n_remaining;

    logic              r_out_valid;
    t_speed            r_out_right, n_out_right;
    t_speed            r_out_left, n_out_left;
    logic              r_out_reverse;
    logic              r_out_turning;
    logic              r_out_accepted;

    logic              advance;
    logic              take_byte;
    logic              check_ok;
    logic              accepted;
    logic [BYTE_W-1:0] check_value;
    logic signed [SPEED_W:0] limit;

    assign advance   = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;
    assign take_byte = r_in_valid && advance && (r_in_command == CMD_BYTE) && !r_turn;

    assign check_value = ~(CH_START + CH_BUTTON + r_button + r_press);
    assign check_ok    = (r_in_byte == check_value);
    assign limit       = (r_max_magnitude > LIMIT_CAP) ? $signed({2'b00, LIMIT_CAP})
                                                       : $signed({2'b00, r_max_magnitude});

    function automatic t_speed brake_one(input t_speed v, input logic rev,
                                         input logic [STEP_W-1:0] b);
        logic signed [SPEED_W:0] w;
        logic signed [SPEED_W:0] r;
        begin
            w = (SPEED_W+1)'(v);
            r = w;
            if (!rev) begin
                if (w > 0) begin
                    r = w - $signed({2'b00, b});
                    if (r < 0) r = '0;
                end
            end else begin
                if (w < 0) begin
                    r = w + $signed({2'b00, b});
                    if (r > 0) r = '0;
                end
            end
            brake_one = r[SPEED_W-1:0];
        end
    endfunction

    function automatic t_speed step_one(input t_speed v, input logic rev,
                                        input logic [STEP_W-1:0] s,
                                        input logic signed [SPEED_W:0] lim);
        logic signed [SPEED_W:0] w;
        logic signed [SPEED_W:0] r;
        begin
            w = (SPEED_W+1)'(v);
            r = w;
            if (!rev) begin
                if (w < lim) begin
                    r = w + $signed({2'b00, s});
                    if (r > lim) r = lim;
                end
            end else begin
                if (w > -lim) begin
                    r = w - $signed({2'b00, s});
                    if (r < -lim) r = -lim;
                end
            end
            step_one = r[SPEED_W-1:0];
        end
    endfunction

    // Parser phase.
    always_comb begin
        n_phase = r_phase;
        if (take_byte) begin
            unique case (r_phase)
                PH_WAIT_START:  n_phase = (r_in_byte == CH_START) ? PH_WAIT_BUTTON
                                                                  : PH_WAIT_START;
                PH_WAIT_BUTTON: n_phase = (r_in_byte == CH_BUTTON) ? PH_GET_CODE
                                                                   : PH_WAIT_START;
                PH_GET_CODE:    n_phase = PH_GET_PRESS;
                PH_GET_PRESS:   n_phase = PH_GET_CHECK;
                PH_GET_CHECK:   n_phase = PH_WAIT_START;
                default:        n_phase = PH_WAIT_START;
            endcase
        end
    end

    // Packet actions, turn timer and the drive word.
    always_comb begin
        n_button     = r_button;
        n_press      = r_press;
        n_right      = r_right;
        n_left       = r_left;
        n_reverse    = r_reverse;
        n_turn       = r_turn;
        n_turn_right = r_turn_right;
        n_remaining  = r_remaining;
        accepted     = 1'b0;

        if (r_in_valid && advance && (r_in_command == CMD_TICK) && r_turn) begin
            if (r_remaining <= TICKS_W'(1)) begin
                n_turn      = 1'b0;
                n_remaining = '0;
            end else begin
                n_remaining = r_remaining - TICKS_W'(1);
            end
        end

        if (take_byte) begin
            if (r_phase == PH_GET_CODE)  n_button = r_in_byte;
            if (r_phase == PH_GET_PRESS) n_press  = r_in_byte;
            if (r_phase == PH_GET_CHECK && check_ok) begin
                accepted = 1'b1;
                if (r_press == CH_PRESS) begin
                    priority if (r_button == CH_BRAKE) begin
                        n_right = brake_one(r_right, r_reverse, r_brake_step);
                        n_left  = brake_one(r_left, r_reverse, r_brake_step);
                    end else if (r_button == CH_UP || r_button == CH_DOWN) begin
                        if (r_reverse != (r_button == CH_DOWN)) begin
                            n_reverse = (r_button == CH_DOWN);
                            n_right   = '0;
                            n_left    = '0;
                        end else begin
                            n_right = step_one(r_right, r_reverse, r_speed_step, limit);
                            n_left  = step_one(r_left, r_reverse, r_speed_step, limit);
                        end
                    end else if (r_button == CH_LEFT || r_button == CH_RIGHT) begin
                        n_turn       = 1'b1;
                        n_turn_right = (r_button == CH_RIGHT);
                        n_remaining  = r_turn_ticks;
                    end else begin
                        n_turn = r_turn;
                    end
                end
            end
        end

        n_out_right = n_right;
        n_out_left  = n_left;
        if (n_turn) begin
            if (n_turn_right) n_out_right = -n_left;
            else              n_out_left  = -n_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brake_step    <= RST_BRAKE_STEP;
            r_speed_step    <= RST_SPEED_STEP;
            r_max_magnitude <= RST_MAX_MAGNITUDE;
            r_turn_ticks    <= RST_TURN_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BRAKE_STEP:    r_brake_step    <= i_cfg_data[STEP_W-1:0];
                CFG_SPEED_STEP:    r_speed_step    <= i_cfg_data[STEP_W-1:0];
                CFG_MAX_MAGNITUDE: r_max_magnitude <= i_cfg_data[STEP_W-1:0];
                CFG_TURN_TICKS:    r_turn_ticks    <= i_cfg_data[TICKS_W-1:0];
                default:           r_turn_ticks    <= r_turn_ticks;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_command <= i_in.command;
            r_in_byte    <= i_in.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAIT_START;
            r_button     <= '0;
            r_press      <= '0;
            r_right      <= '0;
            r_left       <= '0;
            r_reverse    <= 1'b0;
            r_turn       <= 1'b0;
            r_turn_right <= 1'b0;
            r_remaining  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_button     <= n_button;
            r_press      <= n_press;
            r_right      <= n_right;
            r_left       <= n_left;
            r_reverse    <= n_reverse;
            r_turn       <= n_turn;
            r_turn_right <= n_turn_right;
            r_remaining  <= n_remaining;
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_right    <= n_out_right;
            r_out_left     <= n_out_left;
            r_out_reverse  <= n_reverse;
            r_out_turning  <= n_turn;
            r_out_accepted <= accepted;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.right_drive     = r_out_right;
    assign o_out.left_drive      = r_out_left;
    assign o_out.reverse_gear    = r_out_reverse;
    assign o_out.turning         = r_out_turning;
    assign o_out.packet_accepted = r_out_accepted;

endmodule
